### rtl/pgalloc_pkg.sv
// Package for the per-CPU page allocator: field widths, command and status
// codes, default parameters and the controller/datapath interface structs.
// No dependencies.
package pgalloc_pkg;

    localparam int PAGE_W  = 15;
    localparam int CPU_W   = 3;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 8;
    localparam int LEN_W   = 16;

    localparam int DEF_NUM_PAGES = 32768;
    localparam int DEF_NUM_CPUS  = 8;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REF    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_COUNT  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_ready;
    } t_dp_status;

endpackage

### rtl/pgalloc_ctrl.sv
// Controller of the page allocator: clearing pass, accept and execute phases.
// Depends on pgalloc_pkg for the command and status structs.
module pgalloc_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  pgalloc_pkg::t_dp_status i_st,
    output pgalloc_pkg::t_ctl_cmd   o_cmd
);
    import pgalloc_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.clr_step = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.exec     = 1'b0;
        o_s_tready     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // Finish only once the result register can take the beat.
                if (i_st.out_ready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/pgalloc_dp.sv
// Datapath of the page allocator: count and link memories, list heads and
// lengths, free total, configuration register and result register.
// Depends on pgalloc_pkg for widths, codes and interface structs.
module pgalloc_dp #(
    parameter int NUM_PAGES = pgalloc_pkg::DEF_NUM_PAGES,
    parameter int NUM_CPUS  = pgalloc_pkg::DEF_NUM_CPUS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pgalloc_pkg::t_ctl_cmd              i_cmd,
    output pgalloc_pkg::t_dp_status            o_st,
    input  logic [pgalloc_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [pgalloc_pkg::CPU_W-1:0]      i_in_cpu,
    input  logic [pgalloc_pkg::PAGE_W-1:0]     i_in_page,
    input  logic                               i_cfg_we,
    input  logic [pgalloc_pkg::PAGE_W-1:0]     i_cfg_wdata,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [pgalloc_pkg::STAT_W-1:0]     o_status,
    output logic [pgalloc_pkg::PAGE_W-1:0]     o_granted_page,
    output logic                               o_released,
    output logic [pgalloc_pkg::COUNT_W-1:0]    o_new_count,
    output logic [pgalloc_pkg::LEN_W-1:0]      o_free_pages
);
    import pgalloc_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [COUNT_W-1:0] m_count [NUM_PAGES];
    logic [PAGE_W-1:0]  m_link  [NUM_PAGES];

    logic [PAGE_W-1:0]  r_first;
    logic [CMD_W-1:0]   r_op;
    logic [PAGE_W-1:0]  r_page;
    logic [CW-1:0]      r_idx;
    logic               r_any;
    logic [PAGE_W-1:0]  r_head_rd;
    logic [COUNT_W-1:0] r_cnt_rd;
    logic [PAGE_W-1:0]  r_link_rd;
    logic [PAGE_W-1:0]  r_head [NUM_CPUS];
    logic [LEN_W-1:0]   r_len  [NUM_CPUS];
    logic [LEN_W-1:0]   r_total;
    logic [AW-1:0]      r_clr_addr;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [PAGE_W-1:0]  r_granted;
    logic               r_released;
    logic [COUNT_W-1:0] r_new_count;
    logic [LEN_W-1:0]   r_free;

    logic [NUM_CPUS-1:0] nonempty;
    logic [4:0]          cpu_mod;
    logic [CW-1:0]       cpu_m;
    logic [CW-1:0]       sel;
    logic [CW-1:0]       acc_idx;
    logic [AW-1:0]       rd_addr;

    logic               page_ok;
    logic [STAT_W-1:0]  n_status;
    logic [PAGE_W-1:0]  n_granted;
    logic               n_released;
    logic [COUNT_W-1:0] n_new_count;
    logic [LEN_W-1:0]   n_total;
    logic               do_pop;
    logic               do_push;
    logic               cnt_wr;
    logic               cnt_we;
    logic [AW-1:0]      cnt_wa;
    logic [COUNT_W-1:0] cnt_wd;

    // Accept side: pick the list and the memory address to read.
    always_comb begin
        for (int i = 0; i < NUM_CPUS; i++) begin
            nonempty[i] = (r_len[i] != '0);
        end
        // The cpu field is below eight, so a few conditional subtracts
        // reduce it modulo the number of lists.
        cpu_mod = {2'b00, i_in_cpu};
        for (int k = 0; k < 8; k++) begin
            if (cpu_mod >= 5'(NUM_CPUS)) begin
                cpu_mod = cpu_mod - 5'(NUM_CPUS);
            end
        end
        cpu_m = CW'(cpu_mod);
        sel   = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                sel = CW'(i);
            end
        end
        if (nonempty[cpu_m]) begin
            sel = cpu_m;
        end
        acc_idx = (i_in_cmd == CMD_ALLOC) ? sel : cpu_m;
        rd_addr = (i_in_cmd == CMD_ALLOC) ? AW'(r_head[acc_idx]) : AW'(i_in_page);
    end

    // Execute side: result and state updates from the registered reads.
    always_comb begin
        page_ok     = (r_page >= r_first) && ({17'd0, r_page} < 32'(NUM_PAGES));
        n_status    = ST_OK;
        n_granted   = '0;
        n_released  = 1'b0;
        n_new_count = '0;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        cnt_wr      = 1'b0;
        cnt_wa      = AW'(r_page);
        cnt_wd      = '0;
        unique case (r_op)
            CMD_ALLOC: begin
                if (!r_any) begin
                    n_status = ST_NOFREE;
                end else begin
                    n_granted   = r_head_rd;
                    n_new_count = 8'd1;
                    do_pop      = 1'b1;
                    cnt_wr      = 1'b1;
                    cnt_wa      = AW'(r_head_rd);
                    cnt_wd      = 8'd1;
                end
            end
            CMD_FREE: begin
                if (!page_ok) begin
                    n_status = ST_RANGE;
                end else if (r_cnt_rd == '0) begin
                    n_status = ST_COUNT;
                end else begin
                    n_new_count = r_cnt_rd - 8'd1;
                    cnt_wr      = 1'b1;
                    cnt_wd      = n_new_count;
                    if (n_new_count == '0) begin
                        do_push    = 1'b1;
                        n_released = 1'b1;
                    end
                end
            end
            CMD_REF: begin
                if (!page_ok) begin
                    n_status = ST_RANGE;
                end else if (r_cnt_rd == COUNT_MAX) begin
                    n_status    = ST_COUNT;
                    n_new_count = COUNT_MAX;
                end else begin
                    n_new_count = r_cnt_rd + 8'd1;
                    cnt_wr      = 1'b1;
                    cnt_wd      = n_new_count;
                end
            end
            CMD_REPORT: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        n_total = r_total;
        if (do_pop) begin
            n_total = r_total - 16'd1;
        end else if (do_push) begin
            n_total = r_total + 16'd1;
        end
        if (i_cmd.clr_step) begin
            cnt_we = 1'b1;
            cnt_wa = r_clr_addr;
            cnt_wd = 8'd1;
        end else begin
            cnt_we = i_cmd.exec && cnt_wr;
        end
    end

    assign o_st.clr_last  = (r_clr_addr == AW'(NUM_PAGES - 1));
    assign o_st.out_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_count[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.accept) begin
            r_cnt_rd <= m_count[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) begin
            m_link[AW'(r_page)] <= r_head_rd;
        end
        if (i_cmd.accept) begin
            r_link_rd <= m_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_in_cmd;
            r_page    <= i_in_page;
            r_idx     <= acc_idx;
            r_any     <= |nonempty;
            r_head_rd <= r_head[acc_idx];
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_released  <= n_released;
            r_new_count <= n_new_count;
            r_free      <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_total     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_head[i] <= '0;
                r_len[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_first <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.exec) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
                if (do_pop) begin
                    r_head[r_idx] <= r_link_rd;
                    r_len[r_idx]  <= r_len[r_idx] - 16'd1;
                end else if (do_push) begin
                    r_head[r_idx] <= r_page;
                    r_len[r_idx]  <= r_len[r_idx] + 16'd1;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_page = r_granted;
    assign o_released     = r_released;
    assign o_new_count    = r_new_count;
    assign o_free_pages   = r_free;

    a_exec_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_m_tready))
        else $error("result written while the output beat was still held");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_step && (i_cmd.accept || i_cmd.exec)))
        else $error("item handled during the clearing pass");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_released) |-> (r_new_count == '0 && r_status == ST_OK))
        else $error("released page with a nonzero count or an error status");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_granted == '0 && !r_released))
        else $error("failed operation granted or released a page");

endmodule

### rtl/page_allocator_percpu_refcount_core.sv
// Top level of the per-CPU free-list page allocator with reference counts.
// Depends on pgalloc_pkg, pgalloc_ctrl and pgalloc_dp.
//
// Channel    Direction  Handshake                   Contents
// s (item)   in         i_s_tvalid / o_s_tready     tuser: cmd; tdata: cpu, page
// m (result) out        o_m_tvalid / i_m_tready     tuser: status; tdata: results
// cfg        in         i_cfg_we                    i_cfg_wdata: first_usable_page
//
// Each beat has an accept phase, which issues the registered read of the
// count and link memories, and an execute phase, which writes them back and
// loads the result register. A held result only delays the execute phase,
// and the next beat is accepted while the result waits to be taken.
// After reset the block sweeps every entry of the count memory to 1, one
// entry per cycle; o_s_tready stays low meanwhile, and cfg writes are
// taken at any time.
module page_allocator_percpu_refcount_core #(
    parameter int NUM_PAGES = pgalloc_pkg::DEF_NUM_PAGES,
    parameter int NUM_CPUS  = pgalloc_pkg::DEF_NUM_CPUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [2:0] cpu, [17:3] page, [23:18] zero
    input  logic [23:0]                     i_s_tdata,
    // [1:0] cmd
    input  logic [pgalloc_pkg::CMD_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [14:0] granted_page, [15] released, [23:16] new_count, [39:24] free_pages
    output logic [39:0]                     o_m_tdata,
    // [1:0] status
    output logic [pgalloc_pkg::STAT_W-1:0]  o_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [pgalloc_pkg::PAGE_W-1:0]  i_cfg_wdata
);
    import pgalloc_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_st;

    logic [PAGE_W-1:0]  granted_page;
    logic               released;
    logic [COUNT_W-1:0] new_count;
    logic [LEN_W-1:0]   free_pages;

    // The controller sequences the clearing pass and the two phases of
    // each beat; it never touches payload.
    pgalloc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (dp_st),
        .o_cmd      (ctl_cmd)
    );

    // The datapath holds all list, count and result state.
    pgalloc_dp #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_CPUS  (NUM_CPUS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctl_cmd),
        .o_st           (dp_st),
        .i_in_cmd       (i_s_tuser),
        .i_in_cpu       (i_s_tdata[2:0]),
        .i_in_page      (i_s_tdata[17:3]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_status       (o_m_tuser),
        .o_granted_page (granted_page),
        .o_released     (released),
        .o_new_count    (new_count),
        .o_free_pages   (free_pages)
    );

    assign o_m_tdata = {free_pages, new_count, released, granted_page};

endmodule
